// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of the ready queue scheduler.
// Include this header by its bare file name; it depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HRRN_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HRRN_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hrrn_pkg.sv =====
// Package for the ready queue scheduler: sizes, codes, payload structs and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package hrrn_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int EST_BITS    = 24;
  localparam int TIME_BITS   = 32;
  localparam int ID_BITS     = 16;
  localparam int ALPHA_BITS  = 9;
  localparam int STATUS_BITS = 2;

  localparam int IDX_BITS   = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_BITS = ID_BITS + EST_BITS + TIME_BITS;
  localparam int MIX_BITS   = EST_BITS + ALPHA_BITS;
  localparam int PROD_BITS  = TIME_BITS + EST_BITS;

  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;

  localparam logic [ALPHA_BITS-1:0] ALPHA_ONE   = ALPHA_BITS'(256);
  localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = ALPHA_BITS'(128);

  localparam logic CMD_ENQUEUE  = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  localparam logic [STATUS_BITS-1:0] ST_DONE  = STATUS_BITS'(0);
  localparam logic [STATUS_BITS-1:0] ST_FULL  = STATUS_BITS'(1);
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = STATUS_BITS'(2);

  // Register select is address bit 2 (registers sit at byte addresses 0 and 4).
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_ALPHA = 1'b1;

  typedef struct packed {
    logic                 command;
    logic [ID_BITS-1:0]   proc_id;
    logic [EST_BITS-1:0]  prev_estimate;
    logic [EST_BITS-1:0]  burst_time;
    logic                 burst_ended;
    logic [TIME_BITS-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [ID_BITS-1:0]     chosen_id;
    logic [EST_BITS-1:0]    chosen_estimate;
  } out_item_t;

  typedef struct packed {
    logic [ID_BITS-1:0]   proc_id;
    logic [EST_BITS-1:0]  estimate;
    logic [TIME_BITS-1:0] arrival;
  } entry_t;

  typedef enum logic [1:0] {
    RES_ENQ,
    RES_FOUND,
    RES_EMPTY
  } res_sel_e;

  typedef struct packed {
    logic     take_in;
    logic     idx_clr;
    logic     idx_inc;
    logic     idx_from_best;
    logic     enq_write;
    logic     load_best;
    logic     load_cand;
    logic     cmp_update;
    logic     cp_write;
    logic     cnt_dec;
    logic     res_load;
    res_sel_e res_sel;
    logic     out_load;
  } hrrn_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic full;
    logic hrrn;
    logic dispatch;
    logic single;
    logic cand_last;
    logic idx_at_cnt;
    logic rd_last;
    logic out_free;
  } hrrn_stat_t;

endpackage

// ===== hdl/hrrn_ready_queue_scheduler.sv =====
// Ready queue scheduler with first-in first-out or highest-response-ratio-next
// dispatch over a 16-slot queue. Each transaction is handled on its own. An
// HRRN dispatch is paced by the one shared cross-multiply comparator, which
// compares the slots one at a time, and by the compaction that moves one slot
// per cycle through the single read and write port of the slot RAM.
// A finished result waits in an output register, so the next transaction is
// accepted while that result is still stalled; that next transaction then
// holds its own result until the output register is free.
// Depends on hrrn_pkg, hrrn_ctrl, hrrn_dpath and hrrn_ram.
`timescale 1ns / 1ps

module hrrn_ready_queue_scheduler import hrrn_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  hrrn_cmd_t  cmd;
  hrrn_stat_t stat;

  hrrn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hrrn_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

endmodule

// ===== hdl/hrrn_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the ready queue slots; no package dependency.
`timescale 1ns / 1ps

module hrrn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/hrrn_dpath.sv =====
// Datapath of the ready queue scheduler: configuration registers, slot RAM,
// estimate mixer, ratio cross-multiplier and result registers. Uses hrrn_pkg.
`timescale 1ns / 1ps

module hrrn_dpath import hrrn_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hrrn_cmd_t            cmd_i,
  output hrrn_stat_t           stat_o,
  input  in_item_t             in_data_i,
  output out_item_t            out_data_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  function automatic logic [EST_BITS-1:0] est_nz(input logic [EST_BITS-1:0] est);
    return (est == '0) ? EST_BITS'(1) : est;
  endfunction

  logic                  mode_q;
  logic [ALPHA_BITS-1:0] alpha_q;
  logic [CNT_BITS-1:0]   cnt_q;
  logic [CNT_BITS-1:0]   idx_q;
  logic                  out_valid_q;
  in_item_t              item_q;
  logic [MIX_BITS-1:0]   mix_a_q, mix_b_q;
  logic [PROD_BITS-1:0]  prod_new_q, prod_old_q;
  logic [IDX_BITS-1:0]   raddr_q;
  logic [IDX_BITS-1:0]   best_idx_q, cand_idx_q;
  logic [TIME_BITS-1:0]  best_wait_q, cand_wait_q;
  logic [EST_BITS-1:0]   best_est_q, cand_est_q;
  logic [ID_BITS-1:0]    best_proc_q, cand_proc_q;
  out_item_t             res_q, res_d;
  out_item_t             out_q;

  logic                  cfg_we;
  logic [ALPHA_BITS-1:0] alpha_sat;
  logic [MIX_BITS:0]     mix_sum;
  logic [EST_BITS-1:0]   est_new;
  logic [CNT_BITS-1:0]   cnt_m1;
  logic                  full;
  logic [ENTRY_BITS-1:0] ram_rdata, ram_wdata;
  logic [IDX_BITS-1:0]   ram_waddr;
  logic                  ram_we;
  entry_t                rentry;
  logic [TIME_BITS-1:0]  rwait;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_comb begin
    case (paddr[2])
      REG_MODE:  prdata = DATA_BITS'(mode_q);
      REG_ALPHA: prdata = DATA_BITS'(alpha_q);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      alpha_q <= ALPHA_RESET;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_MODE:  mode_q  <= pwdata[0];
        REG_ALPHA: alpha_q <= pwdata[ALPHA_BITS-1:0];
        default:   mode_q  <= mode_q;
      endcase
    end
  end

  // Exponential average of the estimate in HRRN mode when a burst ended.
  assign alpha_sat = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
  assign mix_sum   = (MIX_BITS + 1)'(mix_a_q) + (MIX_BITS + 1)'(mix_b_q);
  assign est_new   = (mode_q && item_q.burst_ended) ? mix_sum[EST_BITS+7:8]
                                                    : item_q.prev_estimate;

  assign cnt_m1 = cnt_q - CNT_BITS'(1);
  assign full   = (cnt_q == CNT_BITS'(QUEUE_DEPTH));

  // Slot storage. Compaction moves the word just read one slot down.
  assign rentry    = entry_t'(ram_rdata);
  assign rwait     = item_q.now_time - rentry.arrival;
  assign ram_we    = cmd_i.enq_write | cmd_i.cp_write;
  assign ram_waddr = cmd_i.cp_write ? (raddr_q - IDX_BITS'(1)) : cnt_q[IDX_BITS-1:0];
  assign ram_wdata = cmd_i.cp_write ? ram_rdata
                                    : {item_q.proc_id, est_new, item_q.now_time};

  hrrn_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q[IDX_BITS-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.enq_write) begin
        cnt_q <= cnt_q + CNT_BITS'(1);
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_m1;
      end

      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_from_best) begin
        idx_q <= CNT_BITS'(best_idx_q) + CNT_BITS'(1);
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + CNT_BITS'(1);
      end

      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    res_d = res_q;
    case (cmd_i.res_sel)
      RES_ENQ: begin
        res_d.status          = full ? ST_FULL : ST_DONE;
        res_d.chosen_id       = item_q.proc_id;
        res_d.chosen_estimate = est_new;
      end
      RES_FOUND: begin
        res_d.status          = ST_DONE;
        res_d.chosen_id       = best_proc_q;
        res_d.chosen_estimate = best_est_q;
      end
      default: begin
        res_d.status          = ST_EMPTY;
        res_d.chosen_id       = '0;
        res_d.chosen_estimate = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      item_q <= in_data_i;
    end
    raddr_q <= idx_q[IDX_BITS-1:0];

    mix_a_q <= MIX_BITS'(alpha_sat) * MIX_BITS'(item_q.burst_time);
    mix_b_q <= MIX_BITS'(ALPHA_ONE - alpha_sat) * MIX_BITS'(item_q.prev_estimate);

    // The candidate replaces the best when its ratio is at least as high.
    prod_new_q <= PROD_BITS'(cand_wait_q) * PROD_BITS'(est_nz(best_est_q));
    prod_old_q <= PROD_BITS'(best_wait_q) * PROD_BITS'(est_nz(cand_est_q));

    if (cmd_i.load_best) begin
      best_idx_q  <= raddr_q;
      best_wait_q <= rwait;
      best_est_q  <= rentry.estimate;
      best_proc_q <= rentry.proc_id;
    end else if (cmd_i.cmp_update && (prod_new_q >= prod_old_q)) begin
      best_idx_q  <= cand_idx_q;
      best_wait_q <= cand_wait_q;
      best_est_q  <= cand_est_q;
      best_proc_q <= cand_proc_q;
    end

    if (cmd_i.load_cand) begin
      cand_idx_q  <= raddr_q;
      cand_wait_q <= rwait;
      cand_est_q  <= rentry.estimate;
      cand_proc_q <= rentry.proc_id;
    end

    if (cmd_i.res_load) begin
      res_q <= res_d;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    stat_o.cnt_zero   = (cnt_q == '0);
    stat_o.full       = full;
    stat_o.hrrn       = mode_q;
    stat_o.dispatch   = (item_q.command == CMD_DISPATCH);
    stat_o.single     = (cnt_q == CNT_BITS'(1));
    stat_o.cand_last  = (CNT_BITS'(cand_idx_q) == cnt_m1);
    stat_o.idx_at_cnt = (idx_q == cnt_q);
    stat_o.rd_last    = (CNT_BITS'(raddr_q) == cnt_m1);
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

endmodule

// ===== hdl/hrrn_ctrl.sv =====
// Controller state machine of the ready queue scheduler. Sequences enqueue,
// slot scan, compaction and result hand-off. Uses hrrn_pkg.
`timescale 1ns / 1ps

module hrrn_ctrl import hrrn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  hrrn_stat_t stat_i,
  output hrrn_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_ENQ   = 4'd2;
  localparam logic [3:0] S_LD0   = 4'd3;
  localparam logic [3:0] S_LDC   = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_CPS   = 4'd7;
  localparam logic [3:0] S_CPR   = 4'd8;
  localparam logic [3:0] S_CPW   = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.res_sel = RES_ENQ;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d       = S_START;
        end
      end
      S_START: begin
        if (!stat_i.dispatch) begin
          state_d = S_ENQ;
        end else if (stat_i.cnt_zero) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_EMPTY;
          state_d        = S_OUT;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_LD0;
        end
      end
      S_ENQ: begin
        cmd_o.res_load  = 1'b1;
        cmd_o.res_sel   = RES_ENQ;
        cmd_o.enq_write = !stat_i.full;
        state_d         = S_OUT;
      end
      S_LD0: begin
        cmd_o.load_best = 1'b1;
        cmd_o.idx_inc   = 1'b1;
        state_d         = (stat_i.hrrn && !stat_i.single) ? S_LDC : S_CPS;
      end
      S_LDC: begin
        cmd_o.load_cand = 1'b1;
        state_d         = S_MUL;
      end
      S_MUL: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp_update = 1'b1;
        if (stat_i.cand_last) begin
          state_d = S_CPS;
        end else begin
          cmd_o.load_cand = 1'b1;
          cmd_o.idx_inc   = 1'b1;
          state_d         = S_MUL;
        end
      end
      S_CPS: begin
        cmd_o.idx_from_best = 1'b1;
        state_d             = S_CPR;
      end
      S_CPR: begin
        // Nothing to move when the removed entry was the last one.
        if (stat_i.idx_at_cnt) begin
          state_d = S_FIN;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_CPW;
        end
      end
      S_CPW: begin
        cmd_o.cp_write = 1'b1;
        if (stat_i.rd_last) begin
          state_d = S_FIN;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_FIN: begin
        cmd_o.cnt_dec  = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = RES_FOUND;
        state_d        = S_OUT;
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/hrrn_chk.sv =====
// Port-level checker for the ready queue scheduler, bound to the top level.
// Depends on hrrn_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hrrn_chk import hrrn_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o,
  input logic      pready
);

  // One transaction at a time: the input side closes right after acceptance.
  `HRRN_ASSERT_NXT(a_stall_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input accepted while previous transaction is in flight")

  `HRRN_ASSERT_IMP(a_status_legal, clk_i, rst_ni, out_valid_o, out_data_o.status == ST_DONE || out_data_o.status == ST_FULL || out_data_o.status == ST_EMPTY, "illegal status code")

  `HRRN_ASSERT_IMP(a_empty_zero, clk_i, rst_ni, out_valid_o && out_data_o.status == ST_EMPTY, out_data_o.chosen_id == '0 && out_data_o.chosen_estimate == '0, "empty result carries data")

  `HRRN_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")

  `HRRN_ASSERT_IMP(a_pready_high, clk_i, rst_ni, 1'b1, pready, "configuration port not ready")

endmodule

bind hrrn_ready_queue_scheduler hrrn_chk u_hrrn_chk (.*);
